// ----- hw/rtl/bleasp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the advertising sensor record parser.
// Used by the front, queue, back and top-level modules; no dependencies.
package bleasp_pkg;

  // Record framing
  localparam logic [7:0] MfgType   = 8'hFF;
  localparam logic [7:0] CompanyLo = 8'hAF;
  localparam logic [7:0] CompanyHi = 8'h6F;
  localparam logic [7:0] AppId     = 8'hBB;
  localparam logic [7:0] MinData   = 8'd9;
  localparam logic [3:0] HdrBytes  = 4'd3;
  localparam logic [3:0] LastIndex = 4'd15;

  // Action codes carried in tuser
  localparam logic ActReport   = 1'b0;
  localparam logic ActDistance = 1'b1;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgManualMode   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgManualAngle  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgOverrideEn   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgOverrideCo2  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgOverrideTemp = 3'd4;

  // Angle rule constants
  localparam logic [6:0]  AngleMax   = 7'd90;
  localparam logic [16:0] NumMax     = 17'd90000;
  localparam logic [15:0] Div100Mul  = 16'd41944;   // ceil(2^22 / 100)
  localparam int unsigned Div100Sh   = 22;
  localparam logic [17:0] Div1000Mul = 18'd134218;  // ceil(2^27 / 1000)
  localparam int unsigned Div1000Sh  = 27;

  // Queue depth between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  typedef enum logic [3:0] {
    PH_LEN  = 4'b0001,
    PH_TYPE = 4'b0010,
    PH_DATA = 4'b0100,
    PH_HALT = 4'b1000
  } phase_e;

  // One finished sensor record
  typedef struct packed {
    logic [15:0] distance;
    logic [15:0] humidity;
    logic [15:0] co2;
    logic [15:0] temp;
  } rec_t;

  // Configuration seen by the back end
  typedef struct packed {
    logic        man_en;
    logic [6:0]  man_deg;
    logic        override_enable;
    logic [15:0] override_co2;
    logic [7:0]  override_temp;
  } cfg_t;

endpackage
`default_nettype wire

// ----- hw/rtl/bleasp_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Front end: walks report bytes as length/type/data records, tracks distance,
// and pushes one rec_t per matching manufacturer record. Uses bleasp_pkg.
module bleasp_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              beat_i,
  input  wire logic              action_i,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              report_last_i,
  input  wire logic [15:0]       distance_sample_i,
  output logic                   push_o,
  output bleasp_pkg::rec_t       rec_o
);
  import bleasp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  remain_q, remain_d;
  logic [3:0]  index_q, index_d;
  logic        cand_q, cand_d;
  logic [23:0] header_q, header_d;
  logic [47:0] payload_q, payload_d;
  logic [15:0] dist_q, dist_d;
  logic [7:0]  remain_dec;
  logic        hdr_match;
  logic        emit;

  assign remain_dec = remain_q - 8'd1;
  assign hdr_match  = (header_q[7:0] == CompanyLo) && (header_q[15:8] == CompanyHi) &&
                      (header_q[23:16] == AppId);

  // Parse one beat
  always_comb begin
    phase_d   = phase_q;
    remain_d  = remain_q;
    index_d   = index_q;
    cand_d    = cand_q;
    header_d  = header_q;
    payload_d = payload_q;
    dist_d    = dist_q;
    emit      = 1'b0;
    if (beat_i) begin
      if (action_i == ActDistance) begin
        dist_d = distance_sample_i;
      end else begin
        unique case (phase_q)
          PH_LEN: begin
            if (!report_last_i) begin
              if (data_byte_i == 8'd0) begin
                phase_d = PH_HALT;
              end else begin
                remain_d = data_byte_i;
                phase_d  = PH_TYPE;
              end
            end
          end
          PH_TYPE: begin
            remain_d = remain_dec;
            cand_d   = (data_byte_i == MfgType) && (remain_dec >= MinData);
            index_d  = 4'd0;
            phase_d  = (remain_dec == 8'd0) ? PH_LEN : PH_DATA;
          end
          PH_DATA: begin
            // capture header then payload, skip extra bytes
            if (index_q < HdrBytes) begin
              header_d[index_q[1:0]*8 +: 8] = data_byte_i;
            end else if (index_q < MinData[3:0]) begin
              payload_d[(3'(index_q - HdrBytes))*8 +: 8] = data_byte_i;
            end
            if (index_q < LastIndex) begin
              index_d = index_q + 4'd1;
            end
            remain_d = remain_dec;
            if (remain_dec == 8'd0) begin
              emit    = cand_q && hdr_match;
              phase_d = PH_LEN;
            end
          end
          PH_HALT: begin
            phase_d = PH_HALT;
          end
          default: begin
            phase_d = PH_LEN;
          end
        endcase
        // report end restarts the walk
        if (report_last_i) begin
          phase_d  = PH_LEN;
          remain_d = 8'd0;
          index_d  = 4'd0;
          cand_d   = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_LEN;
      remain_q <= 8'd0;
      index_q  <= 4'd0;
      cand_q   <= 1'b0;
      dist_q   <= 16'd0;
    end else begin
      phase_q  <= phase_d;
      remain_q <= remain_d;
      index_q  <= index_d;
      cand_q   <= cand_d;
      dist_q   <= dist_d;
    end
  end

  always_ff @(posedge clk_i) begin
    header_q  <= header_d;
    payload_q <= payload_d;
  end

  // Build the record from big-endian payload bytes
  assign push_o        = emit;
  assign rec_o.temp     = {payload_d[7:0], payload_d[15:8]};
  assign rec_o.co2      = {payload_d[23:16], payload_d[31:24]};
  assign rec_o.humidity = {payload_d[39:32], payload_d[47:40]};
  assign rec_o.distance = dist_q;

  a_push_from_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (phase_q == PH_DATA) && cand_q && beat_i && (action_i == ActReport))
    else $error("record pushed outside a data byte of a candidate record");

endmodule
`default_nettype wire

// ----- hw/rtl/bleasp_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Short record queue between the front and back ends.
// Uses bleasp_pkg for rec_t and the queue depth.
module bleasp_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire bleasp_pkg::rec_t  rec_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   empty_o,
  output bleasp_pkg::rec_t       rec_o
);
  import bleasp_pkg::*;

  rec_t             mem [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QPtrW:0]   cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (QPtrW+1)'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rec_o   = mem[rd_q];

  // Advance pointers and fill level
  always_comb begin
    wr_d  = do_push ? wr_q + QPtrW'(1) : wr_q;
    rd_d  = do_pop ? rd_q + QPtrW'(1) : rd_q;
    cnt_d = cnt_q + (QPtrW+1)'(do_push) - (QPtrW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_q] <= rec_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("record pushed into a full queue");

  a_count_tracks_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q[QPtrW-1:0] == QPtrW'(wr_q - rd_q)) && (cnt_q <= (QPtrW+1)'(QDepth)))
    else $error("queue fill level disagrees with pointers");

endmodule
`default_nettype wire

// ----- hw/rtl/bleasp_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Back end: three-stage pipeline that derives the servo angle from a queued
// record and holds the result in the output register. Uses bleasp_pkg.
module bleasp_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bleasp_pkg::cfg_t  cfg_i,
  input  wire logic              empty_i,
  input  wire bleasp_pkg::rec_t  rec_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output bleasp_pkg::rec_t       out_rec_o,
  output logic [6:0]             out_angle_o
);
  import bleasp_pkg::*;

  logic               adv;
  logic               s1_valid_q, s2_valid_q, s3_valid_q;
  rec_t               s1_rec_q, s2_rec_q, s3_rec_q;
  logic [31:0]        s1_prod_q, s1_prod_d;
  logic               s1_neg_q;
  logic [15:0]        abs_temp;
  logic [9:0]         t_quot;
  logic signed [10:0] t_rx, sel_temp;
  logic [15:0]        sel_co2;
  logic signed [11:0] t_off;
  logic [22:0]        co2_term;
  logic signed [22:0] t_off_x, temp_term;
  logic signed [25:0] n_d, s2_n_q;
  logic [34:0]        div_prod;
  logic [6:0]         rule_angle, angle_d, s3_angle_q;

  // Whole pipeline moves when the output register is free or drained
  assign adv   = !s3_valid_q || out_ready_i;
  assign pop_o = adv && !empty_i;

  // Stage 1: magnitude of temperature times reciprocal of 100
  assign abs_temp  = rec_i.temp[15] ? (~rec_i.temp + 16'd1) : rec_i.temp;
  assign s1_prod_d = 32'(abs_temp) * 32'(Div100Mul);

  // Stage 2: whole degrees, input select, numerator of the angle rule
  assign t_quot    = s1_prod_q[Div100Sh +: 10];
  assign t_rx      = s1_neg_q ? -$signed({1'b0, t_quot}) : $signed({1'b0, t_quot});
  assign sel_temp  = cfg_i.override_enable ? 11'($signed(cfg_i.override_temp)) : t_rx;
  assign sel_co2   = cfg_i.override_enable ? cfg_i.override_co2 : s1_rec_q.co2;
  assign t_off     = 12'(sel_temp) - 12'sd20;
  assign t_off_x   = 23'(t_off);
  assign co2_term  = 23'(sel_co2) * 23'd90;
  assign temp_term = t_off_x * 23'sd1500;
  assign n_d       = $signed(26'(co2_term)) + 26'(temp_term);

  // Stage 3: clamp, divide by 1000, manual select
  assign div_prod = 35'(s2_n_q[16:0]) * 35'(Div1000Mul);
  always_comb begin
    priority if (s2_n_q < 26'sd0) begin
      rule_angle = 7'd0;
    end else if (s2_n_q > $signed(26'(NumMax))) begin
      rule_angle = AngleMax;
    end else begin
      rule_angle = div_prod[Div1000Sh +: 7];
    end
    if (cfg_i.man_en) begin
      angle_d = (cfg_i.man_deg > AngleMax) ? AngleMax : cfg_i.man_deg;
    end else begin
      angle_d = rule_angle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= pop_o;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_rec_q   <= rec_i;
      s1_prod_q  <= s1_prod_d;
      s1_neg_q   <= rec_i.temp[15];
      s2_rec_q   <= s1_rec_q;
      s2_n_q     <= n_d;
      s3_rec_q   <= s2_rec_q;
      s3_angle_q <= angle_d;
    end
  end

  assign out_valid_o = s3_valid_q;
  assign out_rec_o   = s3_rec_q;
  assign out_angle_o = s3_angle_q;

  a_angle_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q |-> (s3_angle_q <= AngleMax))
    else $error("servo angle above full scale");

  a_result_from_stage2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s3_valid_q) |-> $past(s2_valid_q))
    else $error("result appeared without a stage-2 record");

endmodule
`default_nettype wire

// ----- hw/rtl/ble_adv_sensor_record_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Parses BLE advertising reports one byte per beat and reports matching
// sensor records (manufacturer type 0xFF, company 0x6FAF, app 0xBB, nine or
// more data bytes) with temperature, CO2, humidity, the latest distance and a
// servo angle. Input beats are taken one per cycle; the front end only stops
// taking beats when the four-record queue is full. A result is offered from
// the output register after its record has been through the queue and the
// three-stage angle pipeline (divide by 100, angle numerator, divide by 1000
// and clamp). Configuration registers are written through the cfg channel,
// which is always ready, and take effect for results computed after the
// write.
module ble_adv_sensor_record_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [7:0] data_byte, [23:8] distance_sample
  input  wire logic [0:0]  s_axis_tuser,   // [0] action
  input  wire logic        s_axis_tlast,   // report_last
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,   // [15:0] co2_ppm, [31:16] humidity_centi,
                                           // [47:32] temp_centi, [54:48] servo_angle,
                                           // [70:55] distance, [71] zero
  // configuration writes
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [bleasp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [15:0]                   cfg_data_i
);
  import bleasp_pkg::*;

  cfg_t  cfg_q, cfg_d;
  logic  in_beat;
  logic  push, full, pop, empty;
  rec_t  front_rec, queue_rec, out_rec;
  logic  out_valid;
  logic [6:0] out_angle;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgManualMode:   cfg_d.man_en          = cfg_data_i[0];
        CfgManualAngle:  cfg_d.man_deg         = cfg_data_i[6:0];
        CfgOverrideEn:   cfg_d.override_enable = cfg_data_i[0];
        CfgOverrideCo2:  cfg_d.override_co2    = cfg_data_i;
        CfgOverrideTemp: cfg_d.override_temp   = cfg_data_i[7:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.man_en          <= 1'b0;
      cfg_q.man_deg         <= 7'd0;
      cfg_q.override_enable <= 1'b0;
      cfg_q.override_co2    <= 16'd400;
      cfg_q.override_temp   <= 8'd25;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Take beats while the queue has room
  assign s_axis_tready = !full;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  bleasp_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .beat_i            (in_beat),
    .action_i          (s_axis_tuser[0]),
    .data_byte_i       (s_axis_tdata[7:0]),
    .report_last_i     (s_axis_tlast),
    .distance_sample_i (s_axis_tdata[23:8]),
    .push_o            (push),
    .rec_o             (front_rec)
  );

  bleasp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (front_rec),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .rec_o   (queue_rec)
  );

  bleasp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .rec_i       (queue_rec),
    .pop_o       (pop),
    .out_valid_o (out_valid),
    .out_ready_i (m_axis_tready),
    .out_rec_o   (out_rec),
    .out_angle_o (out_angle)
  );

  // Pack the result beat
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_rec.distance, out_angle, out_rec.temp,
                          out_rec.humidity, out_rec.co2};

endmodule
`default_nettype wire
